FILE: rtl/core/hmmd_pkg.sv
// ----------------------------------------------------------------------------
// hmmd_pkg
// Shared types and constants for the handheld memory map decoder.
// ----------------------------------------------------------------------------
package hmmd_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_VIDEO_BANK = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WORK_BANK  = 2'd1;

    localparam logic [2:0] TGT_LOCAL    = 3'd0;
    localparam logic [2:0] TGT_CART_ROM = 3'd1;
    localparam logic [2:0] TGT_CART_RAM = 3'd2;
    localparam logic [2:0] TGT_SERIAL   = 3'd3;
    localparam logic [2:0] TGT_TIMER    = 3'd4;
    localparam logic [2:0] TGT_IRQ_FLAG = 3'd5;
    localparam logic [2:0] TGT_VIDEO    = 3'd6;
    localparam logic [2:0] TGT_UNMAPPED = 3'd7;

    localparam logic [7:0] FILL_NIBBLE = 8'h11;
    localparam logic [7:0] OPEN_BUS    = 8'hFF;

    typedef struct packed {
        logic        action;
        logic [15:0] bus_address;
        logic [7:0]  write_byte;
    } cmd_t;

    typedef struct packed {
        logic [7:0]  read_byte;
        logic [2:0]  target;
        logic [14:0] target_offset;
        logic        forward_write;
        logic [7:0]  forward_byte;
    } result_t;

    typedef struct packed {
        logic    ram_hit;
        logic    irq_hit;
        result_t resp;
    } dec_t;

endpackage

FILE: rtl/core/hmmd_ram.sv
// ----------------------------------------------------------------------------
// hmmd_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module hmmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem[addr] <= wdata;
            else
                rdata <= mem[addr];
        end
    end

endmodule

FILE: rtl/core/hmmd_decode.sv
// ----------------------------------------------------------------------------
// hmmd_decode
// Address decoder: maps one bus word onto the unified RAM, the interrupt
// enable byte, a forwarded target or a fixed read value.
// ----------------------------------------------------------------------------
module hmmd_decode #(
    parameter int WORK_BANKS  = 8,
    parameter int VIDEO_BANKS = 2,
    parameter int AW          = 16
) (
    input  hmmd_pkg::cmd_t  cmd,
    input  logic            video_bank,
    input  logic [2:0]      work_bank,
    output hmmd_pkg::dec_t  dec,
    output logic [AW-1:0]   mem_addr
);
    import hmmd_pkg::*;

    localparam int VRAM_BASE = WORK_BANKS * 4096;
    localparam int OAM_BASE  = VRAM_BASE + VIDEO_BANKS * 8192;
    localparam int HRAM_BASE = OAM_BASE + 256;

    logic [15:0] a;
    logic [7:0]  low;
    logic        wr;

    assign a   = cmd.bus_address;
    assign low = a[7:0];
    assign wr  = cmd.action;

    always_comb
    begin
        dec           = '0;
        mem_addr      = '0;
        if (a < 16'h8000)
        begin
            dec.resp.target        = TGT_CART_ROM;
            dec.resp.target_offset = a[14:0];
        end
        else if (a < 16'hA000)
        begin
            dec.ram_hit = 1'b1;
            mem_addr    = AW'(VRAM_BASE) + (AW'(video_bank) << 13) + AW'(a[12:0]);
        end
        else if (a < 16'hC000)
        begin
            dec.resp.target        = TGT_CART_RAM;
            dec.resp.target_offset = {2'b00, a[12:0]};
        end
        else if (a < 16'hD000)
        begin
            dec.ram_hit = 1'b1;
            mem_addr    = AW'(a[11:0]);
        end
        else if (a < 16'hE000)
        begin
            dec.ram_hit = 1'b1;
            mem_addr    = (AW'(work_bank) << 12) | AW'(a[11:0]);
        end
        else if (a < 16'hFE00)
        begin
            dec.ram_hit = 1'b1;
            mem_addr    = AW'(a[12:0]);
        end
        else if (a < 16'hFEA0)
        begin
            dec.ram_hit = 1'b1;
            mem_addr    = AW'(OAM_BASE) + AW'(a[7:0]);
        end
        else if (a < 16'hFF00)
        begin
            if (!wr)
                dec.resp.read_byte = {a[7:4], a[7:4]};
        end
        else if (a == 16'hFFFF)
        begin
            dec.irq_hit = 1'b1;
        end
        else if (a >= 16'hFF80)
        begin
            dec.ram_hit = 1'b1;
            mem_addr    = AW'(HRAM_BASE) + AW'(a[6:0]);
        end
        else
        begin
            dec.resp.target_offset = {7'd0, low};
            if (low == 8'h01 || low == 8'h02)
                dec.resp.target = TGT_SERIAL;
            else if (low >= 8'h04 && low <= 8'h07)
                dec.resp.target = TGT_TIMER;
            else if (low == 8'h0F)
                dec.resp.target = TGT_IRQ_FLAG;
            else if (low >= 8'h40 && low <= 8'h45)
                dec.resp.target = TGT_VIDEO;
            else
            begin
                dec.resp.target = TGT_UNMAPPED;
                if (!wr)
                    dec.resp.read_byte = OPEN_BUS;
            end
        end

        if (wr && dec.resp.target != TGT_LOCAL && dec.resp.target != TGT_UNMAPPED)
        begin
            dec.resp.forward_write = 1'b1;
            dec.resp.forward_byte  = cmd.write_byte;
        end
    end

endmodule

FILE: rtl/core/handheld_memory_map_decoder_top.sv
// ----------------------------------------------------------------------------
// handheld_memory_map_decoder_top
// Bus decoder for a handheld console memory map with local RAM stores.
//
//   channel   dir  handshake            payload
//   command   in   start && !busy       cmd    (hmmd_pkg::cmd_t)
//   result    out  done, one cycle      result (hmmd_pkg::result_t)
//   config    in   wr_en                wr_index, wr_data
//
// One word accepted per cycle while busy is low; its result appears with done
// in the cycle after, as the unified RAM read is registered. After reset busy
// stays high for a clearing pass that zeroes all WORK_BANKS*4096 +
// VIDEO_BANKS*8192 + 384 RAM words (49536 at the defaults). Results cannot be stalled.
// ----------------------------------------------------------------------------
module handheld_memory_map_decoder_top #(
    parameter int WORK_BANKS  = 8,
    parameter int VIDEO_BANKS = 2
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  hmmd_pkg::cmd_t                       cmd,
    output logic                                 done,
    output hmmd_pkg::result_t                    result,
    input  logic                                 wr_en,
    input  logic [hmmd_pkg::CFG_INDEX_W-1:0]     wr_index,
    input  logic [hmmd_pkg::CFG_DATA_W-1:0]      wr_data
);
    import hmmd_pkg::*;

    localparam int DEPTH = WORK_BANKS * 4096 + VIDEO_BANKS * 8192 + 384;
    localparam int AW    = $clog2(DEPTH);

    logic          video_bank_reg, video_bank_next;
    logic [2:0]    work_bank_reg, work_bank_next;
    logic [7:0]    irq_reg;
    logic          clear_reg;
    logic [AW-1:0] clear_cnt_reg;
    logic          done_reg;
    logic          ram_rd_reg;
    logic          irq_rd_reg;
    result_t       resp_reg, resp_next;

    dec_t          dec;
    logic [AW-1:0] dec_addr;
    logic          accept;
    logic          ram_en, ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata, ram_q;
    logic [2:0]    wb;

    assign accept = start && !clear_reg;
    assign busy   = clear_reg;

    // wrap the work bank and remap zero to one
    always_comb
    begin
        wb = wr_data;
        for (int i = 0; i < 8; i++)
        begin
            if ({1'b0, wb} >= 4'(WORK_BANKS))
                wb = wb - 3'(WORK_BANKS);
        end
        if (wb == 3'd0)
            wb = 3'd1;

        video_bank_next = video_bank_reg;
        work_bank_next  = work_bank_reg;
        if (wr_en && wr_index == CFG_VIDEO_BANK)
            video_bank_next = (VIDEO_BANKS > 1) ? wr_data[0] : 1'b0;
        if (wr_en && wr_index == CFG_WORK_BANK)
            work_bank_next = wb;
    end

    hmmd_decode #(
        .WORK_BANKS  (WORK_BANKS),
        .VIDEO_BANKS (VIDEO_BANKS),
        .AW          (AW)
    ) u_decode (
        .cmd        (cmd),
        .video_bank (video_bank_reg),
        .work_bank  (work_bank_reg),
        .dec        (dec),
        .mem_addr   (dec_addr)
    );

    always_comb
    begin
        if (clear_reg)
        begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = clear_cnt_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_en    = accept && dec.ram_hit;
            ram_we    = cmd.action;
            ram_addr  = dec_addr;
            ram_wdata = cmd.write_byte;
        end
    end

    hmmd_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            video_bank_reg <= 1'b0;
            work_bank_reg  <= 3'd1;
            irq_reg        <= '0;
            clear_reg      <= 1'b1;
            clear_cnt_reg  <= '0;
            done_reg       <= 1'b0;
            ram_rd_reg     <= 1'b0;
            irq_rd_reg     <= 1'b0;
        end
        else
        begin
            video_bank_reg <= video_bank_next;
            work_bank_reg  <= work_bank_next;
            if (clear_reg)
            begin
                clear_cnt_reg <= clear_cnt_reg + AW'(1);
                if (clear_cnt_reg == AW'(DEPTH - 1))
                    clear_reg <= 1'b0;
            end
            if (accept && dec.irq_hit && cmd.action)
                irq_reg <= cmd.write_byte;
            done_reg   <= accept;
            ram_rd_reg <= accept && dec.ram_hit && !cmd.action;
            irq_rd_reg <= accept && dec.irq_hit && !cmd.action;
        end
    end

    always_comb
    begin
        resp_next = dec.resp;
        if (dec.irq_hit && !cmd.action)
            resp_next.read_byte = irq_reg;
    end

    // hold the decoded response for the result cycle
    always_ff @(posedge clk)
    begin
        if (accept)
            resp_reg <= resp_next;
    end

    always_comb
    begin
        result = resp_reg;
        if (ram_rd_reg)
            result.read_byte = ram_q;
        if (!done_reg)
            result = '0;
    end

    assign done = done_reg;

    a_accept_done : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("accepted word produced no result");

    a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("result without accepted word");

    a_fwd_target : assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.forward_write) |->
            (result.target != TGT_LOCAL && result.target != TGT_UNMAPPED))
        else $error("forward write on local or unmapped target");

    a_read_local : assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.read_byte != 8'd0) |->
            (result.target == TGT_LOCAL || result.target == TGT_UNMAPPED))
        else $error("read data on forwarded target");

    a_one_source : assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_rd_reg && irq_rd_reg))
        else $error("two read sources at once");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the handheld memory map decoder. Every accepted bus word runs
// through a local copy of the memory map, its stores and its bank selects,
// and each done word must match the oldest decoded access field by field.
// Covers the region edges, bank switching, spare register indexes and
// random traffic, with and without idle gaps on the command side.
// ----------------------------------------------------------------------------
module tb;
    import hmmd_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int VRAM_DEPTH     = 2 * 8192;
    localparam int WRAM_DEPTH     = 8 * 4096;
    localparam int OAM_DEPTH      = 160;
    localparam int HRAM_DEPTH     = 127;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef enum logic [2:0] {ST_NONE, ST_VRAM, ST_WRAM, ST_OAM, ST_HRAM, ST_IE} store_t;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    cmd_t                   cmd;
    logic                   done;
    result_t                result;
    logic                   wr_en;
    logic [CFG_INDEX_W-1:0] wr_index;
    logic [CFG_DATA_W-1:0]  wr_data;

    logic [7:0] vram_copy [0:VRAM_DEPTH-1];
    logic [7:0] wram_copy [0:WRAM_DEPTH-1];
    logic [7:0] oam_copy  [0:OAM_DEPTH-1];
    logic [7:0] hram_copy [0:HRAM_DEPTH-1];
    logic [7:0] ie_copy;
    logic       vbank_sel;
    logic [2:0] wbank_sel;

    result_t decoded_results [$];
    int      errors       = 0;
    int      stall_cycles = 0;

    handheld_memory_map_decoder_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .done     (done),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic result_t decode_access(input cmd_t c);
        result_t     r;
        store_t      st;
        int unsigned idx;
        logic [15:0] a;
        logic [2:0]  wsel;
        logic [7:0]  cur;
        r    = '0;
        st   = ST_NONE;
        idx  = 0;
        cur  = 8'h00;
        a    = c.bus_address;
        wsel = (wbank_sel == 3'd0) ? 3'd1 : wbank_sel;
        if (a < 16'h8000)
        begin
            r.target        = TGT_CART_ROM;
            r.target_offset = a[14:0];
        end
        else if (a < 16'hA000)
        begin
            st  = ST_VRAM;
            idx = 32'({vbank_sel, a[12:0]});
        end
        else if (a < 16'hC000)
        begin
            r.target        = TGT_CART_RAM;
            r.target_offset = 15'(a - 16'hA000);
        end
        else if (a < 16'hD000)
        begin
            st  = ST_WRAM;
            idx = 32'(a[11:0]);
        end
        else if (a < 16'hE000)
        begin
            st  = ST_WRAM;
            idx = 32'({wsel, a[11:0]});
        end
        else if (a < 16'hFE00)
        begin
            st  = ST_WRAM;
            idx = 32'(a - 16'hE000);
        end
        else if (a < 16'hFEA0)
        begin
            st  = ST_OAM;
            idx = 32'(a - 16'hFE00);
        end
        else if (a < 16'hFF00)
        begin
            if (c.action == ACT_READ)
                r.read_byte = {4'h0, a[7:4]} * FILL_NIBBLE;
        end
        else if (a == 16'hFFFF)
        begin
            st = ST_IE;
        end
        else if (a >= 16'hFF80)
        begin
            st  = ST_HRAM;
            idx = 32'(a - 16'hFF80);
        end
        else
        begin
            r.target_offset = {7'd0, a[7:0]};
            if (a[7:0] == 8'h01 || a[7:0] == 8'h02)
                r.target = TGT_SERIAL;
            else if (a[7:0] >= 8'h04 && a[7:0] <= 8'h07)
                r.target = TGT_TIMER;
            else if (a[7:0] == 8'h0F)
                r.target = TGT_IRQ_FLAG;
            else if (a[7:0] >= 8'h40 && a[7:0] <= 8'h45)
                r.target = TGT_VIDEO;
            else
                r.target = TGT_UNMAPPED;
            if (r.target == TGT_UNMAPPED && c.action == ACT_READ)
                r.read_byte = OPEN_BUS;
        end

        case (st)
            ST_VRAM:
            begin
                cur = vram_copy[idx];
                if (c.action == ACT_WRITE)
                    vram_copy[idx] = c.write_byte;
            end
            ST_WRAM:
            begin
                cur = wram_copy[idx];
                if (c.action == ACT_WRITE)
                    wram_copy[idx] = c.write_byte;
            end
            ST_OAM:
            begin
                cur = oam_copy[idx];
                if (c.action == ACT_WRITE)
                    oam_copy[idx] = c.write_byte;
            end
            ST_HRAM:
            begin
                cur = hram_copy[idx];
                if (c.action == ACT_WRITE)
                    hram_copy[idx] = c.write_byte;
            end
            ST_IE:
            begin
                cur = ie_copy;
                if (c.action == ACT_WRITE)
                    ie_copy = c.write_byte;
            end
            default:
            begin
            end
        endcase
        if (st != ST_NONE && c.action == ACT_READ)
            r.read_byte = cur;

        if (c.action == ACT_WRITE && r.target != TGT_LOCAL && r.target != TGT_UNMAPPED)
        begin
            r.forward_write = 1'b1;
            r.forward_byte  = c.write_byte;
        end
        return r;
    endfunction

    function automatic cmd_t bus_word(input logic act, input logic [15:0] adr,
                                      input logic [7:0] dat);
        cmd_t c;
        c.action      = act;
        c.bus_address = adr;
        c.write_byte  = dat;
        return c;
    endfunction

    // region: 0 cart rom, 1 video, 2 work bank 0, 3 switched work, 4 echo,
    // 5 cart ram, 6 object, 7 unusable, 8 io, 9 high, 10 irq enable, 11 any
    function automatic cmd_t random_access(input int lo, input int hi);
        cmd_t c;
        bit   near;
        near          = ($urandom_range(0, 1) == 1);
        c.action      = 1'($urandom_range(0, 1));
        c.write_byte  = 8'($urandom_range(0, 255));
        c.bus_address = 16'($urandom_range(0, 16'hFFFF));
        case ($urandom_range(lo, hi))
            0: c.bus_address = 16'($urandom_range(0, 16'h7FFF));
            1: c.bus_address = 16'(16'h8000 + (near ? $urandom_range(0, 15)
                                                    : $urandom_range(0, 16'h1FFF)));
            2: c.bus_address = 16'(16'hC000 + (near ? $urandom_range(0, 15)
                                                    : $urandom_range(0, 16'h0FFF)));
            3: c.bus_address = 16'(16'hD000 + (near ? $urandom_range(0, 15)
                                                    : $urandom_range(0, 16'h0FFF)));
            4:
            begin
                if (near)
                    c.bus_address = 16'(16'hE000
                                        + ($urandom_range(0, 1) ? 16'h1000 : 16'h0000)
                                        + $urandom_range(0, 15));
                else
                    c.bus_address = 16'(16'hE000 + $urandom_range(0, 16'h1DFF));
            end
            5: c.bus_address = 16'(16'hA000 + $urandom_range(0, 16'h1FFF));
            6: c.bus_address = 16'(16'hFE00 + (near ? $urandom_range(0, 7)
                                                    : $urandom_range(0, OAM_DEPTH - 1)));
            7: c.bus_address = 16'(16'hFEA0 + $urandom_range(0, 16'h5F));
            8:
            begin
                if (!near)
                    c.bus_address = 16'(16'hFF00 + $urandom_range(0, 16'h7F));
                else
                begin
                    case ($urandom_range(0, 3))
                        0: c.bus_address = 16'(16'hFF01 + $urandom_range(0, 1));
                        1: c.bus_address = 16'(16'hFF04 + $urandom_range(0, 3));
                        2: c.bus_address = 16'hFF0F;
                        default: c.bus_address = 16'(16'hFF40 + $urandom_range(0, 5));
                    endcase
                end
            end
            9: c.bus_address = 16'(16'hFF80 + (near ? $urandom_range(0, 7)
                                                    : $urandom_range(0, HRAM_DEPTH - 1)));
            10: c.bus_address = 16'hFFFF;
            default:
            begin
            end
        endcase
        return c;
    endfunction

    task automatic check_field(input string name, input logic [14:0] want,
                               input logic [14:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (decoded_results.size() == 0)
            begin
                $display("%0t: unexpected word, expected none actual %h", $time, result);
                errors++;
            end
            else
            begin
                want = decoded_results.pop_front();
                check_field("read_byte", 15'(want.read_byte), 15'(result.read_byte));
                check_field("target", 15'(want.target), 15'(result.target));
                check_field("target_offset", want.target_offset, result.target_offset);
                check_field("forward_write", 15'(want.forward_write),
                            15'(result.forward_write));
                check_field("forward_byte", 15'(want.forward_byte),
                            15'(result.forward_byte));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[handheld_memory_map_decoder_top] ERROR");
            $finish;
        end
    end

    // hold start until the word is taken; leave it high for a following word
    task automatic send_word(input cmd_t c);
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        decoded_results.push_back(decode_access(c));
    endtask

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        cmd   <= 25'($urandom);
        repeat (n)
            @(posedge clk);
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (decoded_results.size() != 0)
            @(posedge clk);
        repeat (3)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        settle();
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(posedge clk);
        wr_en    <= 1'b0;
        case (idx)
            CFG_VIDEO_BANK: vbank_sel = val[0];
            CFG_WORK_BANK:  wbank_sel = val;
            default:
            begin
            end
        endcase
    endtask

    task automatic send_traffic(input int count, input int lo, input int hi,
                                input int idle_pct);
        for (int j = 0; j < count; j++)
        begin
            while ($urandom_range(0, 99) < idle_pct)
                idle_cycles(1);
            send_word(random_access(lo, hi));
        end
    endtask

    task automatic apply_reset();
        for (int i = 0; i < VRAM_DEPTH; i++)
            vram_copy[i] = 8'h00;
        for (int i = 0; i < WRAM_DEPTH; i++)
            wram_copy[i] = 8'h00;
        for (int i = 0; i < OAM_DEPTH; i++)
            oam_copy[i] = 8'h00;
        for (int i = 0; i < HRAM_DEPTH; i++)
            hram_copy[i] = 8'h00;
        ie_copy   = 8'h00;
        vbank_sel = 1'b0;
        wbank_sel = 3'd1;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        send_word(bus_word(ACT_READ,  16'h0000, 8'h00));
        send_word(bus_word(ACT_WRITE, 16'h7FFF, 8'hFF));
        send_word(bus_word(ACT_READ,  16'hFFFF, 8'hFF));
        send_word(bus_word(ACT_WRITE, 16'h8000, 8'hA5));
        send_word(bus_word(ACT_READ,  16'h8000, 8'h00));
        send_word(bus_word(ACT_WRITE, 16'h9FFF, 8'hFF));
        send_word(bus_word(ACT_WRITE, 16'hA000, 8'h00));
        send_word(bus_word(ACT_READ,  16'hBFFF, 8'h00));
        send_word(bus_word(ACT_WRITE, 16'hC000, 8'h5A));
        send_word(bus_word(ACT_READ,  16'hE000, 8'h00));
        send_word(bus_word(ACT_WRITE, 16'hD000, 8'h3C));
        send_word(bus_word(ACT_READ,  16'hF000, 8'h00));
        send_word(bus_word(ACT_WRITE, 16'hFDFF, 8'h81));
        send_word(bus_word(ACT_READ,  16'hDDFF, 8'h00));
        send_word(bus_word(ACT_WRITE, 16'hFE00, 8'h11));
        send_word(bus_word(ACT_READ,  16'hFE9F, 8'h00));
        send_word(bus_word(ACT_READ,  16'hFEA0, 8'h00));
        send_word(bus_word(ACT_READ,  16'hFEFF, 8'h00));
        send_word(bus_word(ACT_WRITE, 16'hFEF0, 8'hAB));
        send_word(bus_word(ACT_WRITE, 16'hFF01, 8'h55));
        send_word(bus_word(ACT_WRITE, 16'hFF04, 8'hC3));
        send_word(bus_word(ACT_READ,  16'hFF0F, 8'h00));
        send_word(bus_word(ACT_READ,  16'hFF45, 8'h00));
        send_word(bus_word(ACT_READ,  16'hFF03, 8'h00));
        send_word(bus_word(ACT_WRITE, 16'hFF7F, 8'h77));
        send_word(bus_word(ACT_WRITE, 16'hFFFF, 8'hFF));
        send_word(bus_word(ACT_READ,  16'hFFFF, 8'h00));
        send_word(bus_word(ACT_WRITE, 16'hFF80, 8'h01));
    endtask

    task automatic test_bank_select();
        for (int k = 0; k < 8; k++)
        begin
            write_reg(CFG_VIDEO_BANK, 3'(k));
            write_reg(CFG_WORK_BANK, 3'(7 - k));
            send_traffic(40, 1, 4, 29);
        end
    endtask

    task automatic test_spare_index();
        write_reg(CFG_VIDEO_BANK, 3'd1);
        write_reg(CFG_WORK_BANK, 3'd5);
        write_reg(CFG_SPARE_A, 3'd6);
        write_reg(CFG_SPARE_B, 3'd2);
        send_traffic(24, 1, 4, 29);
    endtask

    task automatic test_random_traffic();
        for (int p = 0; p < 5; p++)
        begin
            write_reg(CFG_VIDEO_BANK, 3'($urandom_range(0, 7)));
            write_reg(CFG_WORK_BANK, 3'($urandom_range(0, 7)));
            send_traffic(70, 0, 11, 29);
        end
    endtask

    task automatic test_back_to_back();
        send_traffic(120, 0, 11, 0);
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        start    <= 1'b0;
        cmd      <= '0;
        wr_en    <= 1'b0;
        wr_index <= '0;
        wr_data  <= '0;
        apply_reset();
        test_directed();
        test_bank_select();
        test_spare_index();
        test_random_traffic();
        test_back_to_back();
        settle();
        if (errors == 0)
            $display("[handheld_memory_map_decoder_top] OK");
        else
            $display("[handheld_memory_map_decoder_top] ERROR");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/hmmd_pkg.sv
rtl/core/hmmd_ram.sv
rtl/core/hmmd_decode.sv
rtl/core/handheld_memory_map_decoder_top.sv
tb/tb.sv
